FILE: design/ffht_pkg.sv
// Shared constants and types for the first-fragment hold table.
package ffht_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int NUM_TIMEOUTS = 8;
    localparam int PRIO_W = 3;
    localparam int TICK_W = 32;
    localparam int TIMEOUT_W = 16;
    localparam int CIRCUIT_W = 8;
    localparam int SEQ_W = 16;
    localparam int CLASS_W = 3;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_INDEX_W = 8;

    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 24;

    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic MODE_SAVE = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET [NUM_TIMEOUTS] =
        '{16'd800, 16'd800, 16'd600, 16'd600, 16'd400, 16'd400, 16'd200, 16'd200};

    typedef struct packed {
        logic                 mode;
        logic [TICK_W-1:0]    now_tick;
        logic [CIRCUIT_W-1:0] circuit;
        logic [SEQ_W-1:0]     seq_number;
        logic [PRIO_W-1:0]    priority_req;
        logic [CLASS_W-1:0]   traffic_class;
        logic [HANDLE_W-1:0]  packet_handle;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [CLASS_W-1:0]  class_id;
    } result_t;

endpackage

FILE: design/first_fragment_hold_table.sv
// First-fragment hold table: slot store, scan sequencer and shared adder.
//
// Usage:
//   Input words arrive on s_axis_*; tuser carries mode (0 save, 1 find),
//   tdata the fragment fields. Each input word yields exactly one result
//   word on m_axis_*: tuser is the status, tdata the handle and class.
//   Timeouts per priority are written through cfg_*; the user writes them
//   only while the table is idle, which the block itself does not enforce.
//   cfg_ready is always high and indexes above 7 are dropped. A save
//   first forms the deadline in the prep state, then probes one slot per
//   cycle round-robin from the slot after the last one used, stopping at the
//   first empty or expired slot (at most SLOTS probes). A find probes slots
//   from 0 one per cycle until a match (at most SLOTS probes). The result
//   then waits in the response state until it moves into the output register;
//   the single slot probe and 32-bit adder are each used once per cycle.
//   s_axis_tready is high only while idle, so one word is handled at a time.
//   If the receiver stalls, the finished result waits in the sequencer and
//   the output register holds; no new item is taken until it moves on.
//   Reset empties all slots, sets the round-robin pointer to 0 and loads the
//   default timeouts.
module first_fragment_hold_table (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_tick[31:0], circuit[39:32], seq_number[55:40], priority_req[58:56],
    // traffic_class[61:59], packet_handle[77:62], zero fill [79:78]
    input  logic [ffht_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // mode[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_handle[15:0], out_class[18:16], zero fill [23:19]
    output logic [ffht_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[2:0]
    output logic [ffht_pkg::STATUS_W-1:0]         m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ffht_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ffht_pkg::TIMEOUT_W-1:0]        cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    localparam logic [ffht_pkg::SLOT_W-1:0] LAST_IDX =
        ffht_pkg::SLOT_W'(ffht_pkg::SLOTS - 1);

    logic [1:0] state_reg, state_next;
    logic [ffht_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic [ffht_pkg::SLOT_W-1:0] ptr_reg, ptr_next;
    ffht_pkg::item_t item_reg;
    logic [ffht_pkg::TICK_W-1:0] deadline_reg;
    ffht_pkg::result_t res_reg, res_next;
    ffht_pkg::result_t out_reg;
    logic out_valid_reg;

    logic [ffht_pkg::TIMEOUT_W-1:0] timeout_reg [ffht_pkg::NUM_TIMEOUTS];

    logic                             slot_valid_reg   [ffht_pkg::SLOTS];
    logic [ffht_pkg::CIRCUIT_W-1:0]   slot_circuit_reg [ffht_pkg::SLOTS];
    logic [ffht_pkg::SEQ_W-1:0]       slot_seq_reg     [ffht_pkg::SLOTS];
    logic [ffht_pkg::HANDLE_W-1:0]    slot_handle_reg  [ffht_pkg::SLOTS];
    logic [ffht_pkg::CLASS_W-1:0]     slot_class_reg   [ffht_pkg::SLOTS];
    logic [ffht_pkg::TICK_W-1:0]      slot_deadline_reg[ffht_pkg::SLOTS];

    logic in_fire;
    logic out_free;
    logic is_save;
    logic [ffht_pkg::SLOT_W-1:0] rr_idx;
    logic [ffht_pkg::SLOT_W-1:0] probe_idx;
    logic [ffht_pkg::TICK_W-1:0] add_a, add_b, add_sum;
    logic add_sub;
    logic expired;
    logic match;
    logic place;
    logic hit;
    ffht_pkg::item_t in_item;

    assign in_item = '{
        mode:          s_axis_tuser,
        now_tick:      s_axis_tdata[31:0],
        circuit:       s_axis_tdata[39:32],
        seq_number:    s_axis_tdata[55:40],
        priority_req:  s_axis_tdata[58:56],
        traffic_class: s_axis_tdata[61:59],
        packet_handle: s_axis_tdata[77:62]
    };

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign is_save = (item_reg.mode == ffht_pkg::MODE_SAVE);

    assign rr_idx = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign probe_idx = is_save ? rr_idx : cnt_reg;

    // shared adder: deadline = now + timeout, then deadline - now per probe
    always_comb
    begin
        if (state_reg == S_PREP)
        begin
            add_a = item_reg.now_tick;
            add_b = {{(ffht_pkg::TICK_W - ffht_pkg::TIMEOUT_W){1'b0}},
                     timeout_reg[item_reg.priority_req]};
            add_sub = 1'b0;
        end
        else
        begin
            add_a = slot_deadline_reg[probe_idx];
            add_b = item_reg.now_tick;
            add_sub = 1'b1;
        end
    end

    assign add_sum = add_a + (add_sub ? ~add_b : add_b)
                   + {{(ffht_pkg::TICK_W - 1){1'b0}}, add_sub};
    assign expired = add_sum[ffht_pkg::TICK_W-1];

    assign match = slot_valid_reg[probe_idx]
                && (slot_circuit_reg[probe_idx] == item_reg.circuit)
                && (slot_seq_reg[probe_idx] == item_reg.seq_number);
    assign place = (state_reg == S_SCAN) && is_save
                && (!slot_valid_reg[probe_idx] || expired);
    assign hit = (state_reg == S_SCAN) && !is_save && match;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        res_next = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                    state_next = (in_item.mode == ffht_pkg::MODE_SAVE) ? S_PREP : S_SCAN;
            end
            S_PREP:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (is_save)
                begin
                    ptr_next = rr_idx;
                    if (!slot_valid_reg[probe_idx])
                    begin
                        res_next = '{status: ffht_pkg::ST_STORED, handle: '0, class_id: '0};
                        state_next = S_RESP;
                    end
                    else if (expired)
                    begin
                        res_next = '{status:   ffht_pkg::ST_EVICTED,
                                     handle:   slot_handle_reg[probe_idx],
                                     class_id: slot_class_reg[probe_idx]};
                        state_next = S_RESP;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        res_next = '{status: ffht_pkg::ST_FULL, handle: '0, class_id: '0};
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    if (match)
                    begin
                        res_next = '{status:   ffht_pkg::ST_FOUND,
                                     handle:   slot_handle_reg[probe_idx],
                                     class_id: slot_class_reg[probe_idx]};
                        state_next = S_RESP;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        res_next = '{status: ffht_pkg::ST_NOT_FOUND, handle: '0, class_id: '0};
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            ptr_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ffht_pkg::NUM_TIMEOUTS; i++)
                timeout_reg[i] <= ffht_pkg::TIMEOUT_RESET[i];
            for (int i = 0; i < ffht_pkg::SLOTS; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready
                && cfg_index < ffht_pkg::CFG_INDEX_W'(ffht_pkg::NUM_TIMEOUTS))
                timeout_reg[cfg_index[ffht_pkg::PRIO_W-1:0]] <= cfg_data;
            if (place)
                slot_valid_reg[probe_idx] <= 1'b1;
            else if (hit)
                slot_valid_reg[probe_idx] <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_item;
        if (state_reg == S_PREP)
            deadline_reg <= add_sum;
        res_reg <= res_next;
        if (state_reg == S_RESP && out_free)
            out_reg <= res_reg;
        if (place)
        begin
            slot_circuit_reg[probe_idx] <= item_reg.circuit;
            slot_seq_reg[probe_idx] <= item_reg.seq_number;
            slot_handle_reg[probe_idx] <= item_reg.packet_handle;
            slot_class_reg[probe_idx] <= item_reg.traffic_class;
            slot_deadline_reg[probe_idx] <= deadline_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_reg.status;
    assign m_axis_tdata = {{(ffht_pkg::OUT_DATA_W - ffht_pkg::HANDLE_W - ffht_pkg::CLASS_W){1'b0}},
                           out_reg.class_id, out_reg.handle};

`ifndef SYNTHESIS
    // an accepted word always starts a scan or deadline step
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_PREP || state_reg == S_SCAN))
        else $error("sequencer did not start after accepting a word");

    // a result can only be loaded from the response state
    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("output loaded outside response state");

    // plain store, full and miss carry no handle or class
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ffht_pkg::ST_STORED
                           || m_axis_tuser == ffht_pkg::ST_FULL
                           || m_axis_tuser == ffht_pkg::ST_NOT_FOUND))
        |-> (m_axis_tdata == '0))
        else $error("nonzero payload on empty result");

    // no probe both fills and frees a slot
    a_place_or_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !(place && hit))
        else $error("store and remove in the same probe");
`endif

endmodule

FILE: test/tb_first_fragment_hold_table.sv
// Self-checking testbench for the first-fragment hold table: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_first_fragment_hold_table;

    localparam int LONG_HOLD = 200;
    localparam int DRAIN_SLACK = ffht_pkg::SLOTS + 4;
    localparam logic [ffht_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 8'd8;
    localparam logic [ffht_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 8'hFF;

    typedef enum int {TO_RANDOM, TO_MAX, TO_ZERO_SHORT, TO_BRIEF} timeout_plan_t;

    typedef struct {
        ffht_pkg::item_t   frag;
        bit                known;
        ffht_pkg::result_t want;
    } frag_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ffht_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ffht_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [ffht_pkg::STATUS_W-1:0]    m_axis_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ffht_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ffht_pkg::TIMEOUT_W-1:0]   cfg_data = '0;

    // side info that travels with the word currently offered
    ffht_pkg::item_t   offered_frag = '0;
    bit                offered_known = 1'b0;
    ffht_pkg::result_t offered_want = '0;

    // predictor copy of the table
    logic                           held_valid [ffht_pkg::SLOTS];
    logic [ffht_pkg::CIRCUIT_W-1:0] held_circuit [ffht_pkg::SLOTS];
    logic [ffht_pkg::SEQ_W-1:0]     held_seq [ffht_pkg::SLOTS];
    logic [ffht_pkg::HANDLE_W-1:0]  held_handle [ffht_pkg::SLOTS];
    logic [ffht_pkg::CLASS_W-1:0]   held_class [ffht_pkg::SLOTS];
    logic [ffht_pkg::TICK_W-1:0]    held_deadline [ffht_pkg::SLOTS];
    logic [ffht_pkg::TIMEOUT_W-1:0] hold_timeout [ffht_pkg::NUM_TIMEOUTS];
    logic [ffht_pkg::SLOT_W-1:0]    rr_slot;

    ffht_pkg::result_t           pending_results [$];
    frag_row_t                   dir_rows [$];
    int                          mismatches = 0;
    logic [ffht_pkg::TICK_W-1:0] tick_gen;
    bit                          sender_idle_on = 1'b1;
    bit                          receiver_stall_on = 1'b1;
    bit                          hold_out_req = 1'b0;

    first_fragment_hold_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic ffht_pkg::result_t hold_table_apply(ffht_pkg::item_t f);
        ffht_pkg::result_t           r;
        bit                          placed;
        int                          i;
        logic [ffht_pkg::TICK_W-1:0] margin;
        r.status = ffht_pkg::ST_NOT_FOUND;
        r.handle = '0;
        r.class_id = '0;
        placed = 1'b0;
        if (f.mode == ffht_pkg::MODE_SAVE)
        begin
            r.status = ffht_pkg::ST_FULL;
            for (i = 0; i < ffht_pkg::SLOTS && !placed; i++)
            begin
                rr_slot = ffht_pkg::SLOT_W'((int'(rr_slot) + 1) % ffht_pkg::SLOTS);
                // expired when the tick is strictly past the deadline, in wrapping time
                margin = held_deadline[rr_slot] - f.now_tick;
                if (!held_valid[rr_slot])
                begin
                    r.status = ffht_pkg::ST_STORED;
                    placed = 1'b1;
                end
                else if (margin[ffht_pkg::TICK_W-1])
                begin
                    r.status = ffht_pkg::ST_EVICTED;
                    r.handle = held_handle[rr_slot];
                    r.class_id = held_class[rr_slot];
                    placed = 1'b1;
                end
            end
            if (placed)
            begin
                held_valid[rr_slot] = 1'b1;
                held_circuit[rr_slot] = f.circuit;
                held_seq[rr_slot] = f.seq_number;
                held_handle[rr_slot] = f.packet_handle;
                held_class[rr_slot] = f.traffic_class;
                held_deadline[rr_slot] = f.now_tick
                    + ffht_pkg::TICK_W'(hold_timeout[f.priority_req]);
            end
        end
        else
        begin
            for (i = 0; i < ffht_pkg::SLOTS && !placed; i++)
            begin
                if (held_valid[i] && held_circuit[i] == f.circuit
                    && held_seq[i] == f.seq_number)
                begin
                    held_valid[i] = 1'b0;
                    r.status = ffht_pkg::ST_FOUND;
                    r.handle = held_handle[i];
                    r.class_id = held_class[i];
                    placed = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // word handshakes are observed here: results checked, accepted fragments predicted
    always @(posedge clk)
    begin : scoreboard
        ffht_pkg::result_t seen;
        ffht_pkg::result_t want;
        ffht_pkg::result_t predicted;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.status = m_axis_tuser;
                seen.handle = m_axis_tdata[ffht_pkg::HANDLE_W-1:0];
                seen.class_id =
                    m_axis_tdata[ffht_pkg::HANDLE_W+ffht_pkg::CLASS_W-1:ffht_pkg::HANDLE_W];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word: status %0d handle %h class %0d",
                             $time, seen.status, seen.handle, seen.class_id);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want)
                    begin
                        $display({"%0t: expected status %0d handle %h class %0d, ",
                                  "got status %0d handle %h class %0d"},
                                 $time, want.status, want.handle, want.class_id,
                                 seen.status, seen.handle, seen.class_id);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = hold_table_apply(offered_frag);
                pending_results.push_back(offered_known ? offered_want : predicted);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_out_req)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_out_req = 1'b0;
            end
            else if (receiver_stall_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // called and returns at a falling edge
    task automatic offer_fragment(input ffht_pkg::item_t f, input bit known,
                                  input ffht_pkg::result_t want);
        offered_frag = f;
        offered_known = known;
        offered_want = want;
        s_axis_tuser = f.mode;
        s_axis_tdata = {2'b00, f.packet_handle, f.traffic_class, f.priority_req,
                        f.seq_number, f.circuit, f.now_tick};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic add_row(input logic mode, input logic [ffht_pkg::TICK_W-1:0] now,
                           input logic [ffht_pkg::CIRCUIT_W-1:0] circ,
                           input logic [ffht_pkg::SEQ_W-1:0] seq,
                           input logic [ffht_pkg::PRIO_W-1:0] prio,
                           input logic [ffht_pkg::CLASS_W-1:0] cls,
                           input logic [ffht_pkg::HANDLE_W-1:0] hnd, input bit known,
                           input logic [ffht_pkg::STATUS_W-1:0] st,
                           input logic [ffht_pkg::HANDLE_W-1:0] oh,
                           input logic [ffht_pkg::CLASS_W-1:0] oc);
        frag_row_t row;
        row.frag.mode = mode;
        row.frag.now_tick = now;
        row.frag.circuit = circ;
        row.frag.seq_number = seq;
        row.frag.priority_req = prio;
        row.frag.traffic_class = cls;
        row.frag.packet_handle = hnd;
        row.known = known;
        row.want.status = st;
        row.want.handle = oh;
        row.want.class_id = oc;
        dir_rows.push_back(row);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [ffht_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [ffht_pkg::TIMEOUT_W-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx < ffht_pkg::NUM_TIMEOUTS)
            hold_timeout[idx[ffht_pkg::PRIO_W-1:0]] = val;
        @(negedge clk);
    endtask

    task automatic reprogram(input timeout_plan_t plan, input bit spare_too);
        int                             k;
        logic [ffht_pkg::TIMEOUT_W-1:0] val;
        drain_results();
        repeat (DRAIN_SLACK) @(negedge clk);
        for (k = 0; k < ffht_pkg::NUM_TIMEOUTS; k++)
        begin
            case (plan)
                TO_MAX:        val = '1;
                TO_ZERO_SHORT: val = (k % 2 == 0) ? '0
                                   : ffht_pkg::TIMEOUT_W'($urandom_range(1, 8));
                TO_BRIEF:      val = ffht_pkg::TIMEOUT_W'($urandom_range(0, 300));
                default:       val = ffht_pkg::TIMEOUT_W'($urandom_range(0, 65535));
            endcase
            write_timeout(ffht_pkg::CFG_INDEX_W'(k), val);
        end
        // writes to indexes past the timeout bank must be dropped
        if (spare_too)
        begin
            write_timeout(CFG_SPARE_LO, ffht_pkg::TIMEOUT_W'($urandom));
            write_timeout(CFG_SPARE_HI, '1);
        end
        cfg_valid = 1'b0;
    endtask

    function automatic ffht_pkg::item_t random_fragment(int save_pct);
        ffht_pkg::item_t f;
        int              live [$];
        int              i;
        int              pick;
        f.now_tick = tick_gen;
        f.priority_req = ffht_pkg::PRIO_W'($urandom);
        f.traffic_class = ffht_pkg::CLASS_W'($urandom);
        f.packet_handle = ffht_pkg::HANDLE_W'($urandom);
        // narrow keys half the time so duplicate circuit/seq pairs occur
        f.circuit = $urandom_range(0, 1) ? ffht_pkg::CIRCUIT_W'($urandom_range(0, 3))
                                         : ffht_pkg::CIRCUIT_W'($urandom);
        f.seq_number = $urandom_range(0, 1) ? ffht_pkg::SEQ_W'($urandom_range(0, 3))
                                            : ffht_pkg::SEQ_W'($urandom);
        if ($urandom_range(0, 99) < save_pct)
            f.mode = ffht_pkg::MODE_SAVE;
        else
        begin
            f.mode = ffht_pkg::MODE_FIND;
            for (i = 0; i < ffht_pkg::SLOTS; i++)
                if (held_valid[i])
                    live.push_back(i);
            // most finds go after a fragment that is really held
            if (live.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                pick = live[$urandom_range(0, live.size() - 1)];
                f.circuit = held_circuit[pick];
                f.seq_number = held_seq[pick];
            end
        end
        return f;
    endfunction

    task automatic run_phase(input int count, input int save_pct, input int step_max);
        repeat (count)
        begin
            if ($urandom_range(0, 59) == 0)
                tick_gen = tick_gen + ffht_pkg::TICK_W'($urandom);
            else
                tick_gen = tick_gen + ffht_pkg::TICK_W'($urandom_range(0, step_max));
            offer_fragment(random_fragment(save_pct), 1'b0, '0);
        end
    endtask

    initial
    begin : main
        int k;
        for (k = 0; k < ffht_pkg::SLOTS; k++)
        begin
            held_valid[k] = 1'b0;
            held_circuit[k] = '0;
            held_seq[k] = '0;
            held_handle[k] = '0;
            held_class[k] = '0;
            held_deadline[k] = '0;
        end
        for (k = 0; k < ffht_pkg::NUM_TIMEOUTS; k++)
            hold_timeout[k] = ffht_pkg::TIMEOUT_RESET[k];
        rr_slot = '0;
        tick_gen = $urandom;

        // directed rows; the find fields a find ignores carry junk on purpose
        add_row(ffht_pkg::MODE_FIND, 32'h0, 8'h00, 16'h0000, 3'd0, 3'd0, 16'h0000,
                1'b1, ffht_pkg::ST_NOT_FOUND, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_SAVE, 32'h0, 8'hFF, 16'hFFFF, 3'd7, 3'd7, 16'hFFFF,
                1'b1, ffht_pkg::ST_STORED, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_SAVE, 32'h0, 8'h00, 16'h0000, 3'd0, 3'd0, 16'h0000,
                1'b1, ffht_pkg::ST_STORED, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_FIND, 32'h5, 8'hFF, 16'hFFFF, 3'd5, 3'd3, 16'h1234,
                1'b1, ffht_pkg::ST_FOUND, 16'hFFFF, 3'd7);
        add_row(ffht_pkg::MODE_FIND, 32'h6, 8'hFF, 16'hFFFF, 3'd0, 3'd0, 16'h0000,
                1'b1, ffht_pkg::ST_NOT_FOUND, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_FIND, 32'h7, 8'h00, 16'h0000, 3'd7, 3'd7, 16'hFFFF,
                1'b1, ffht_pkg::ST_FOUND, 16'h0000, 3'd0);
        // fill every slot just before the tick wraps; most deadlines land past zero
        for (k = 0; k < ffht_pkg::SLOTS; k++)
            add_row(ffht_pkg::MODE_SAVE, 32'hFFFF_FF00, ffht_pkg::CIRCUIT_W'(k),
                    ffht_pkg::SEQ_W'(16'h8000 | k), ffht_pkg::PRIO_W'(k),
                    ffht_pkg::CLASS_W'(k), ffht_pkg::HANDLE_W'(16'hA000 + k),
                    1'b0, ffht_pkg::ST_STORED, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_SAVE, 32'hFFFF_FF10, 8'h55, 16'h5555, 3'd2, 3'd2, 16'h5555,
                1'b1, ffht_pkg::ST_FULL, 16'h0000, 3'd0);
        add_row(ffht_pkg::MODE_SAVE, 32'h0000_0400, 8'hAA, 16'hAAAA, 3'd1, 3'd5, 16'hAAAA,
                1'b0, ffht_pkg::ST_STORED, 16'h0000, 3'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            offer_fragment(dir_rows[r].frag, dir_rows[r].known, dir_rows[r].want);

        reprogram(TO_RANDOM, 1'b0);
        run_phase(60, 55, 2000);
        drain_results();
        run_phase(65, 55, 2000);

        // long timeouts and mostly saves: the table fills and rejects
        reprogram(TO_MAX, 1'b1);
        hold_out_req = 1'b1;
        run_phase(125, 75, 300);

        // zero and tiny timeouts with a slow tick: evictions, equal-tick deadlines
        reprogram(TO_ZERO_SHORT, 1'b0);
        run_phase(125, 70, 5);

        reprogram(TO_BRIEF, 1'b0);
        sender_idle_on = 1'b0;
        receiver_stall_on = 1'b0;
        run_phase(125, 60, 100);

        drain_results();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
